// ===== rtl/light_map_pixel_blend_macros.svh =====
// Assertion macros for the light map pixel blend.
// Included by the top level; depends on nothing else.
`ifndef LIGHT_MAP_PIXEL_BLEND_MACROS_SVH
`define LIGHT_MAP_PIXEL_BLEND_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LMPB_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LMPB_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lmpb_pkg.sv =====
// Shared types and constants of the light map pixel blend.
// Used by every module and interface instance of the block; depends on nothing.
`default_nettype none

package lmpb_pkg;

  localparam int unsigned ChanW        = 8;
  localparam int unsigned ProdW        = 2 * ChanW;
  localparam int unsigned NumW         = 3 * ChanW + 1;
  localparam int unsigned NumChan      = 3;
  localparam int unsigned DivStages    = 3;
  localparam int unsigned BitsPerStage = 3;
  localparam int unsigned QuoW         = DivStages * BitsPerStage;
  localparam int unsigned CfgIdxW      = 3;

  localparam logic [ChanW-1:0] PixMax = {ChanW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    CfgAmbRed       = 3'd0,
    CfgAmbGreen     = 3'd1,
    CfgAmbBlue      = 3'd2,
    CfgAmbIntensity = 3'd3,
    CfgFullBright   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [ChanW-1:0] light_red;
    logic [ChanW-1:0] light_green;
    logic [ChanW-1:0] light_blue;
    logic [ChanW-1:0] light_alpha;
    logic [ChanW-1:0] sky_visibility;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_alpha;
  } pix_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] idx;
    logic [ChanW-1:0]   wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [ChanW-1:0] amb_red;
    logic [ChanW-1:0] amb_green;
    logic [ChanW-1:0] amb_blue;
    logic [ChanW-1:0] amb_intensity;
    logic             full_bright;
  } cfg_t;

  typedef struct packed {
    logic [NumChan-1:0][ProdW-1:0] ca;
    logic [ProdW-1:0]              s;
    logic [ProdW-1:0]              la;
  } prod_t;

  typedef struct packed {
    logic [NumChan-1:0][NumW-1:0] num;
    logic [ProdW-1:0]             t;
    logic [ChanW-1:0]             alpha;
    logic                         zero;
  } sum_t;

  typedef struct packed {
    logic [NumChan-1:0][NumW-1:0] rem;
    logic [NumChan-1:0][QuoW-1:0] q;
    logic [ProdW-1:0]             t;
    logic [ChanW-1:0]             alpha;
    logic                         zero;
  } div_t;

endpackage

`default_nettype wire

// ===== rtl/lmpb_stream_if.sv =====
// Valid/ready channel carrying one item of a chosen payload type.
// Instanced with types from lmpb_pkg for the pixel and configuration channels.
`default_nettype none

interface lmpb_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lmpb_front.sv =====
// Front stages: byte products, then weighted sums, weight T and alpha.
// Depends on lmpb_pkg.
`default_nettype none

module lmpb_front (
  input  logic           clk_i,
  input  logic [1:0]     en_i,
  input  lmpb_pkg::pix_in_t pix_i,
  input  lmpb_pkg::cfg_t    cfg_i,
  output lmpb_pkg::sum_t    sum_o
);
  import lmpb_pkg::*;

  prod_t prod_d, prod_q;
  sum_t  sum_d, sum_q;

  logic [NumChan-1:0][ChanW-1:0] light_c;
  logic [NumChan-1:0][ChanW-1:0] amb_c;
  logic [ProdW-1:0]              t_max;
  logic [ProdW:0]                alpha_sum;

  always_comb begin
    light_c[0] = pix_i.light_red;
    light_c[1] = pix_i.light_green;
    light_c[2] = pix_i.light_blue;
    amb_c[0]   = cfg_i.amb_red;
    amb_c[1]   = cfg_i.amb_green;
    amb_c[2]   = cfg_i.amb_blue;
  end

  always_comb begin
    prod_d.s  = ProdW'(pix_i.sky_visibility) * ProdW'(cfg_i.amb_intensity);
    prod_d.la = {pix_i.light_alpha, ChanW'(0)} - ProdW'(pix_i.light_alpha);
    for (int c = 0; c < NumChan; c++) begin
      prod_d.ca[c] = ProdW'(light_c[c]) * ProdW'(pix_i.light_alpha);
    end
  end

  // floor(t / 255) as (t + t/256 + 1) / 256, exact for t up to 255 * 255
  always_comb begin
    t_max     = (prod_q.la > prod_q.s) ? prod_q.la : prod_q.s;
    alpha_sum = (ProdW+1)'(t_max) + (ProdW+1)'(t_max >> ChanW) + (ProdW+1)'(1);
    sum_d.t     = t_max;
    sum_d.alpha = alpha_sum[2*ChanW-1 -: ChanW];
    sum_d.zero  = (t_max == '0);
    for (int c = 0; c < NumChan; c++) begin
      sum_d.num[c] = ((NumW'(prod_q.ca[c]) << ChanW) - NumW'(prod_q.ca[c]))
                   + (NumW'(amb_c[c]) * NumW'(prod_q.s));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
    end
    if (en_i[1]) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

// ===== rtl/lmpb_div.sv =====
// Pipelined restoring divider: three quotient bits per stage, all channels.
// Depends on lmpb_pkg.
`default_nettype none

module lmpb_div (
  input  logic                           clk_i,
  input  logic [lmpb_pkg::DivStages-1:0] en_i,
  input  lmpb_pkg::sum_t                 sum_i,
  output lmpb_pkg::div_t                 div_o
);
  import lmpb_pkg::*;

  for (genvar j = 0; j < DivStages; j++) begin : g_stage
    div_t stage_in;
    div_t stage_d;
    div_t stage_q;

    if (j == 0) begin : g_head
      assign stage_in = div_t'{rem: sum_i.num, q: '0, t: sum_i.t, alpha: sum_i.alpha,
                               zero: sum_i.zero};
    end else begin : g_link
      assign stage_in = g_stage[j-1].stage_q;
    end

    always_comb begin
      logic [NumW-1:0] dvs;
      int              k;
      stage_d = stage_in;
      for (int b = 0; b < BitsPerStage; b++) begin
        k   = QuoW - 1 - j * BitsPerStage - b;
        dvs = NumW'(stage_in.t) << k;
        for (int c = 0; c < NumChan; c++) begin
          if (stage_d.rem[c] >= dvs) begin
            stage_d.rem[c]  = stage_d.rem[c] - dvs;
            stage_d.q[c][k] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        stage_q <= stage_d;
      end
    end
  end

  assign div_o = g_stage[DivStages-1].stage_q;

endmodule

`default_nettype wire

// ===== rtl/light_map_pixel_blend.sv =====
// Channel   | Dir | Modport | Payload
// pix_i     | in  | sink    | light_red/green/blue, light_alpha, sky_visibility
// pix_o     | out | source  | out_red/green/blue, out_alpha
// cfg_i     | in  | sink    | idx (register index), wdata
//
// One item per cycle sustained while pix_o is ready; six register stages: products, sums,
// three divider stages of three quotient bits each, output register.
// Ready ripples back from pix_o through empty stages; bubbles are filled.
// Reset clears valid bits and configuration; cfg_i is always ready.
// Top level of the light map pixel blend; uses lmpb_pkg, lmpb_stream_if,
// lmpb_front, lmpb_div and the assertion macros.
`default_nettype none
`include "light_map_pixel_blend_macros.svh"

module light_map_pixel_blend (
  input  logic         clk_i,
  input  logic         rst_ni,
  lmpb_stream_if.sink   pix_i,
  lmpb_stream_if.source pix_o,
  lmpb_stream_if.sink   cfg_i
);
  import lmpb_pkg::*;

  localparam int unsigned NumRegs = 2 + DivStages + 1;

  cfg_t               cfg_d, cfg_q;
  logic [NumRegs-1:0] v_d, v_q;
  logic [NumRegs-1:0] en;
  pix_in_t            pix_in;
  sum_t               sum;
  div_t               div_res;
  pix_out_t           out_d, out_q;
  logic [NumChan-1:0][ChanW-1:0] col;
  logic               out_stall;
  logic               div_live;
  logic               rem_ok;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.data.idx))
        CfgAmbRed:       cfg_d.amb_red       = cfg_i.data.wdata;
        CfgAmbGreen:     cfg_d.amb_green     = cfg_i.data.wdata;
        CfgAmbBlue:      cfg_d.amb_blue      = cfg_i.data.wdata;
        CfgAmbIntensity: cfg_d.amb_intensity = cfg_i.data.wdata;
        CfgFullBright:   cfg_d.full_bright   = cfg_i.data.wdata[0];
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or the one after it advances
  always_comb begin
    en[NumRegs-1] = !v_q[NumRegs-1] || pix_o.ready;
    for (int k = NumRegs - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = en[0] ? pix_i.valid : v_q[0];
    for (int k = 1; k < NumRegs; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
      v_q   <= '0;
    end else begin
      cfg_q <= cfg_d;
      v_q   <= v_d;
    end
  end

  assign pix_i.ready = en[0];
  assign pix_in      = pix_i.data;

  lmpb_front u_front (
    .clk_i (clk_i),
    .en_i  (en[1:0]),
    .pix_i (pix_in),
    .cfg_i (cfg_q),
    .sum_o (sum)
  );

  lmpb_div u_div (
    .clk_i (clk_i),
    .en_i  (en[2 +: DivStages]),
    .sum_i (sum),
    .div_o (div_res)
  );

  // saturate on quotient bit 8, then zero weight, then full bright
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      col[c] = div_res.q[c][QuoW-1] ? PixMax : div_res.q[c][ChanW-1:0];
    end
    out_d.out_red   = col[0];
    out_d.out_green = col[1];
    out_d.out_blue  = col[2];
    out_d.out_alpha = div_res.alpha;
    if (div_res.zero) begin
      out_d = '0;
    end
    if (cfg_q.full_bright) begin
      out_d = '1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NumRegs-1]) begin
      out_q <= out_d;
    end
  end

  assign pix_o.valid = v_q[NumRegs-1];
  assign pix_o.data  = out_q;

  assign out_stall = pix_o.valid && !pix_o.ready;
  assign div_live  = v_q[NumRegs-2] && !div_res.zero;

  always_comb begin
    rem_ok = 1'b1;
    for (int c = 0; c < NumChan; c++) begin
      if (div_res.rem[c] >= NumW'(div_res.t)) begin
        rem_ok = 1'b0;
      end
    end
  end

  `LMPB_ASSERT_IMPL(a_stall_from_out, clk_i, rst_ni, !pix_i.ready, out_stall, "input stall")
  `LMPB_ASSERT_NEXT(a_full_drain, clk_i, rst_ni, (&v_q) && pix_o.ready, pix_o.valid, "item lost")
  `LMPB_ASSERT_IMPL(a_div_rem, clk_i, rst_ni, div_live, rem_ok, "remainder not below divisor")

endmodule

`default_nettype wire
